// ===== sv/stop_order_trigger_table_macros.svh =====
// Assertion macros for the stop order trigger table module.
// Depends on nothing; included inside module bodies.
`ifndef STOP_ORDER_TRIGGER_TABLE_MACROS_SVH
`define STOP_ORDER_TRIGGER_TABLE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SOTT_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define SOTT_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

// ===== sv/sott_pkg.sv =====
// Package for the stop order trigger table: sizes, operation and result codes.
// Depends on nothing.
package sott_pkg;
    localparam int TABLE_SLOTS = 32;
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [2:0] {
        OP_ADD = 3'd0, OP_REPLAY = 3'd1, OP_CANCEL = 3'd2,
        OP_CHECK = 3'd3, OP_TRAIL = 3'd4
    } op_code_t;

    localparam logic [2:0] RES_ADDED = 3'd0;
    localparam logic [2:0] RES_FULL = 3'd1;
    localparam logic [2:0] RES_DUP = 3'd2;
    localparam logic [2:0] RES_CANCELLED = 3'd3;
    localparam logic [2:0] RES_NOT_FOUND = 3'd4;
    localparam logic [2:0] RES_RELEASED = 3'd5;
    localparam logic [2:0] RES_NONE = 3'd6;
    localparam logic [2:0] RES_UPDATED = 3'd7;

    localparam logic [1:0] KIND_LIMIT = 2'd1;
    localparam logic [1:0] KIND_TRAIL = 2'd2;

    // One slot's stored order as seen by the scan unit.
    typedef struct packed {
        logic        buy;
        logic [1:0]  kind;
        logic [31:0] ident;
        logic [31:0] stop;
        logic [31:0] gap;
        logic [31:0] best;
        logic [31:0] age;
    } slot_view_t;
endpackage

// ===== sv/sott_cand.sv =====
// Shared compare unit: decides whether a scanned slot beats the current candidate.
// Depends on sott_pkg.
module sott_cand (
    input  sott_pkg::slot_view_t sv,
    input  logic                 sv_valid,
    input  logic                 side,
    input  logic [31:0]          trade,
    input  logic [31:0]          insert_count,
    input  logic                 have_best,
    input  logic [31:0]          best_stop,
    input  logic [31:0]          best_age,
    output logic                 better
);
    import sott_pkg::*;
    logic        fires;
    logic [31:0] a_cur;
    logic [31:0] a_best;

    always_comb
    begin
        fires = side ? (sv.stop <= trade) : (sv.stop >= trade);
        a_cur = insert_count - sv.age;
        a_best = insert_count - best_age;
        better = sv_valid && (sv.buy == side) && fires &&
                 (!have_best || (sv.stop < best_stop) ||
                  ((sv.stop == best_stop) && (a_cur > a_best)));
    end
endmodule

// ===== sv/stop_order_trigger_table.sv =====
// Stop order trigger table: 32 slots, one slot examined per cycle by a shared unit.
// Add, replay and cancel scan every slot once; so does a trailing update.
// A trigger check scans the table once per released order plus once per side to find
// nothing; busy is high throughout.
// Results appear one cycle each on done with no stall. Reset (rst_n low, async)
// empties the table, sets the next assigned id to one and the insert count to zero.
module stop_order_trigger_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [31:0] ident,
    input  logic        buy_side,
    input  logic [1:0]  kind_code,
    input  logic [31:0] stop_level,
    input  logic [31:0] limit_level,
    input  logic [31:0] trail_gap,
    input  logic [31:0] qty,
    input  logic [31:0] trade_level,
    input  logic [31:0] replay_best,
    output logic        done,
    output logic [2:0]  result_kind,
    output logic [31:0] out_ident,
    output logic        out_buy_side,
    output logic        is_limit,
    output logic [31:0] out_level,
    output logic [31:0] out_qty,
    output logic        last
);
    import sott_pkg::*;
    `include "stop_order_trigger_table_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_WRITE, S_EMIT, S_PICK
    } state_t;

    // Slot storage: valid bits reset; payload written in S_WRITE, stop and best also by a trail scan.
    logic [TABLE_SLOTS-1:0] valid_reg;
    slot_view_t             slot_mem [TABLE_SLOTS];
    logic [31:0]            lim_mem  [TABLE_SLOTS];
    logic [31:0]            qty_mem  [TABLE_SLOTS];

    state_t          state_reg;
    logic [2:0]      op_reg;
    logic [31:0]     id_reg, stop_reg, limit_reg, gap_reg, qty_reg, trade_reg, best_in_reg;
    logic            buy_reg;
    logic [1:0]      kind_reg;
    logic [CNT_W-1:0] idx_reg;
    logic            side_reg;
    logic            found_reg;
    logic [SLOT_W-1:0] hit_reg;
    logic [SLOT_W-1:0] rel_reg;
    logic            have_free_reg;
    logic [SLOT_W-1:0] free_reg;
    logic [31:0]     best_stop_reg, best_age_reg;
    logic            any_rel_reg;
    logic            pend_reg;
    logic [31:0]     next_ident_reg, insert_count_reg;

    logic [SLOT_W-1:0] idx;
    slot_view_t        cur;
    logic              better;
    logic [31:0]       up_sum;

    assign idx = idx_reg[SLOT_W-1:0];
    assign cur = slot_mem[idx];
    assign busy = (state_reg != S_IDLE);

    sott_cand u_cand (
        .sv(cur), .sv_valid(valid_reg[idx]), .side(side_reg), .trade(trade_reg),
        .insert_count(insert_count_reg), .have_best(found_reg),
        .best_stop(best_stop_reg), .best_age(best_age_reg), .better(better)
    );

    assign up_sum = trade_reg + cur.gap;

    // Payload writes of slots (no reset).
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE && have_free_reg && !found_reg)
        begin
            slot_mem[free_reg] <= '{buy: buy_reg, kind: kind_reg, ident: id_reg,
                                    stop: stop_reg, gap: gap_reg,
                                    best: (op_reg == OP_REPLAY) ? best_in_reg : stop_reg,
                                    age: insert_count_reg};
            lim_mem[free_reg] <= limit_reg;
            qty_mem[free_reg] <= qty_reg;
        end
        else if (state_reg == S_SCAN && op_reg == OP_TRAIL && valid_reg[idx] &&
                 cur.kind == KIND_TRAIL)
        begin
            if (cur.buy && trade_reg < cur.best)
            begin
                slot_mem[idx].best <= trade_reg;
                slot_mem[idx].stop <= (trade_reg > ~cur.gap) ? 32'hFFFF_FFFF : up_sum;
            end
            else if (!cur.buy && trade_reg > cur.best)
            begin
                slot_mem[idx].best <= trade_reg;
                slot_mem[idx].stop <= (trade_reg >= cur.gap) ? trade_reg - cur.gap : 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            done <= 1'b0;
            next_ident_reg <= 32'd1;
            insert_count_reg <= '0;
            idx_reg <= '0;
            side_reg <= 1'b1;
            found_reg <= 1'b0;
            have_free_reg <= 1'b0;
            any_rel_reg <= 1'b0;
            pend_reg <= 1'b0;
            result_kind <= '0; out_ident <= '0; out_buy_side <= 1'b0;
            is_limit <= 1'b0; out_level <= '0; out_qty <= '0; last <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    done <= 1'b0;
                    if (start)
                    begin
                        op_reg <= op;
                        id_reg <= (op == OP_ADD && ident == 32'd0) ? next_ident_reg : ident;
                        buy_reg <= buy_side; kind_reg <= kind_code;
                        stop_reg <= stop_level; limit_reg <= limit_level;
                        gap_reg <= trail_gap; qty_reg <= qty;
                        trade_reg <= trade_level; best_in_reg <= replay_best;
                        idx_reg <= '0; found_reg <= 1'b0; have_free_reg <= 1'b0;
                        side_reg <= 1'b1; any_rel_reg <= 1'b0;
                        pend_reg <= (op == OP_ADD && ident == 32'd0);
                        if (op <= OP_TRAIL)
                            state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    done <= 1'b0;
                    if (op_reg == OP_CHECK)
                    begin
                        if (better)
                        begin
                            found_reg <= 1'b1; hit_reg <= idx;
                            best_stop_reg <= cur.stop; best_age_reg <= cur.age;
                        end
                    end
                    else if (op_reg != OP_TRAIL)
                    begin
                        if (valid_reg[idx] && cur.ident == id_reg && !found_reg)
                        begin
                            found_reg <= 1'b1; hit_reg <= idx;
                        end
                        if (!valid_reg[idx] && !have_free_reg)
                        begin
                            have_free_reg <= 1'b1; free_reg <= idx;
                        end
                    end
                    if (idx_reg == CNT_W'(TABLE_SLOTS - 1))
                        state_reg <= (op_reg == OP_CHECK) ? S_PICK : S_WRITE;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_WRITE:
                begin
                    done <= 1'b1; last <= 1'b1;
                    out_ident <= (op_reg == OP_TRAIL) ? 32'd0 : id_reg;
                    out_buy_side <= 1'b0; is_limit <= 1'b0; out_level <= '0; out_qty <= '0;
                    state_reg <= S_IDLE;
                    if (op_reg == OP_TRAIL)
                        result_kind <= RES_UPDATED;
                    else if (op_reg == OP_CANCEL)
                    begin
                        result_kind <= found_reg ? RES_CANCELLED : RES_NOT_FOUND;
                        if (found_reg) valid_reg[hit_reg] <= 1'b0;
                    end
                    else if (found_reg)
                        result_kind <= RES_DUP;
                    else if (!have_free_reg)
                        result_kind <= RES_FULL;
                    else
                    begin
                        result_kind <= RES_ADDED;
                        valid_reg[free_reg] <= 1'b1;
                        insert_count_reg <= insert_count_reg + 32'd1;
                        if (pend_reg)
                            next_ident_reg <= (next_ident_reg == 32'hFFFF_FFFF) ?
                                              32'd1 : next_ident_reg + 32'd1;
                    end
                end
                S_PICK:
                begin
                    // End of a pass. A new winner means the release held from the
                    // previous pass was not the final one, so it goes out now.
                    if (found_reg)
                    begin
                        done <= pend_reg && any_rel_reg;
                        if (pend_reg && any_rel_reg)
                        begin
                            last <= 1'b0;
                            result_kind <= RES_RELEASED;
                            out_ident <= slot_mem[rel_reg].ident;
                            out_buy_side <= slot_mem[rel_reg].buy;
                            is_limit <= (slot_mem[rel_reg].kind == KIND_LIMIT);
                            out_level <= (slot_mem[rel_reg].kind == KIND_LIMIT) ?
                                         lim_mem[rel_reg] : 32'd0;
                            out_qty <= qty_mem[rel_reg];
                        end
                        rel_reg <= hit_reg;
                        valid_reg[hit_reg] <= 1'b0;
                        any_rel_reg <= 1'b1; pend_reg <= 1'b1;
                        found_reg <= 1'b0; idx_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                    else if (side_reg)
                    begin
                        done <= 1'b0;
                        side_reg <= 1'b0; idx_reg <= '0;
                        pend_reg <= pend_reg && any_rel_reg;
                        any_rel_reg <= any_rel_reg;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        done <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // The held release, if any, is the final result of the check.
                    done <= 1'b1; last <= 1'b1;
                    if (!any_rel_reg)
                    begin
                        result_kind <= RES_NONE; out_ident <= '0; out_buy_side <= 1'b0;
                        is_limit <= 1'b0; out_level <= '0; out_qty <= '0;
                    end
                    else
                    begin
                        result_kind <= RES_RELEASED;
                        out_ident <= slot_mem[rel_reg].ident;
                        out_buy_side <= slot_mem[rel_reg].buy;
                        is_limit <= (slot_mem[rel_reg].kind == KIND_LIMIT);
                        out_level <= (slot_mem[rel_reg].kind == KIND_LIMIT) ?
                                     lim_mem[rel_reg] : 32'd0;
                        out_qty <= qty_mem[rel_reg];
                    end
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    done <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A result strobe always ends in idle or continues a release scan.
    `SOTT_ASSERT_IMP(a_last_idle, clk, rst_n, done && last, state_reg == S_SCAN || state_reg == S_IDLE, "final result outside idle")
    `SOTT_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy && op <= OP_TRAIL, busy, "accepted request did not raise busy")
    `SOTT_ASSERT_IMP(a_release_kind, clk, rst_n, done && !last, result_kind == RES_RELEASED, "non-final result is not a release")
endmodule

// ===== tb/sv/stop_order_trigger_table_tb.sv =====
// Self-checking testbench for the stop order trigger table: directed and random requests.
// Depends on sott_pkg and the stop_order_trigger_table RTL; predicts every result itself.
module stop_order_trigger_table_tb;
    import sott_pkg::*;

    localparam int SLOTS = TABLE_SLOTS;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [2:0] OP_SPARE = 3'd5;
    localparam logic [1:0] KIND_MARKET = 2'd0;
    localparam logic [1:0] KIND_ODD = 2'd3;

    // One request as applied to the block's input ports.
    typedef struct {
        logic [2:0]  op;
        logic [31:0] ident;
        logic        buy;
        logic [1:0]  kind;
        logic [31:0] stop;
        logic [31:0] limit;
        logic [31:0] gap;
        logic [31:0] qty;
        logic [31:0] trade;
        logic [31:0] rbest;
    } request_t;

    // One result as it appears on the output ports.
    typedef struct {
        logic [2:0]  kind;
        logic [31:0] ident;
        logic        buy;
        logic        is_lim;
        logic [31:0] level;
        logic [31:0] qty;
        logic        last;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  op;
    logic [31:0] ident;
    logic        buy_side;
    logic [1:0]  kind_code;
    logic [31:0] stop_level;
    logic [31:0] limit_level;
    logic [31:0] trail_gap;
    logic [31:0] qty;
    logic [31:0] trade_level;
    logic [31:0] replay_best;
    logic        done;
    logic [2:0]  result_kind;
    logic [31:0] out_ident;
    logic        out_buy_side;
    logic        is_limit;
    logic [31:0] out_level;
    logic [31:0] out_qty;
    logic        last;

    stop_order_trigger_table dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .op(op), .ident(ident), .buy_side(buy_side), .kind_code(kind_code),
        .stop_level(stop_level), .limit_level(limit_level), .trail_gap(trail_gap),
        .qty(qty), .trade_level(trade_level), .replay_best(replay_best),
        .done(done), .result_kind(result_kind), .out_ident(out_ident),
        .out_buy_side(out_buy_side), .is_limit(is_limit), .out_level(out_level),
        .out_qty(out_qty), .last(last)
    );

    // Mirror of the order table, kept by the predictor.
    logic        book_valid [SLOTS];
    logic        book_buy [SLOTS];
    logic [1:0]  book_kind [SLOTS];
    logic [31:0] book_ident [SLOTS];
    logic [31:0] book_stop [SLOTS];
    logic [31:0] book_limit [SLOTS];
    logic [31:0] book_gap [SLOTS];
    logic [31:0] book_best [SLOTS];
    logic [31:0] book_qty [SLOTS];
    logic [31:0] book_age [SLOTS];
    logic [31:0] id_counter;
    logic [31:0] insert_stamp;

    request_t pending_requests[$];
    outcome_t expected_outcomes[$];
    int       failures = 0;
    int       cycle_count = 0;
    bit       stimulus_done = 0;

    // Clock: 20 time units per period.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("stop_order_trigger_table_tb NOT OK");
            $finish;
        end
    end

    function automatic outcome_t make_outcome(logic [2:0] k, logic [31:0] id);
        outcome_t o;
        o.kind = k;
        o.ident = id;
        o.buy = 1'b0;
        o.is_lim = 1'b0;
        o.level = '0;
        o.qty = '0;
        o.last = 1'b1;
        return o;
    endfunction

    // Appends one predicted result behind those already waiting.
    task automatic expect_outcome(outcome_t o);
        expected_outcomes.insert(expected_outcomes.size(), o);
    endtask

    function automatic int lookup_ident(logic [31:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (book_valid[i] && book_ident[i] == id)
                return i;
        return -1;
    endfunction

    // Next order of one side to fire at this trade price: lowest stop,
    // and among equal stops the one that has waited longest.
    function automatic int next_to_fire(logic side, logic [31:0] trade);
        int sel;
        logic fires;
        logic [31:0] wait_i;
        logic [31:0] wait_sel;
        sel = -1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!book_valid[i] || book_buy[i] != side)
                continue;
            fires = side ? (book_stop[i] <= trade) : (book_stop[i] >= trade);
            if (!fires)
                continue;
            if (sel < 0)
            begin
                sel = i;
                continue;
            end
            wait_i = insert_stamp - book_age[i];
            wait_sel = insert_stamp - book_age[sel];
            if (book_stop[i] < book_stop[sel] ||
                (book_stop[i] == book_stop[sel] && wait_i > wait_sel))
                sel = i;
        end
        return sel;
    endfunction

    // Applies one accepted request to the mirror and queues what it yields.
    task automatic predict_request(request_t r);
        logic        auto_id;
        logic [31:0] id;
        logic [31:0] headroom;
        int          slot;
        int          released;
        outcome_t    o;
        case (r.op)
            OP_ADD, OP_REPLAY:
            begin
                auto_id = (r.op == OP_ADD) && (r.ident == 0);
                id = auto_id ? id_counter : r.ident;
                slot = -1;
                if (lookup_ident(id) >= 0)
                    expect_outcome(make_outcome(RES_DUP, id));
                else
                begin
                    for (int i = 0; i < SLOTS; i++)
                        if (!book_valid[i] && slot < 0)
                            slot = i;
                    if (slot < 0)
                        expect_outcome(make_outcome(RES_FULL, id));
                    else
                    begin
                        book_valid[slot] = 1'b1;
                        book_buy[slot] = r.buy;
                        book_kind[slot] = r.kind;
                        book_ident[slot] = id;
                        book_stop[slot] = r.stop;
                        book_limit[slot] = r.limit;
                        book_gap[slot] = r.gap;
                        book_best[slot] = (r.op == OP_REPLAY) ? r.rbest : r.stop;
                        book_qty[slot] = r.qty;
                        book_age[slot] = insert_stamp;
                        insert_stamp = insert_stamp + 1;
                        if (auto_id)
                        begin
                            id_counter = id_counter + 1;
                            // The assigned id never comes back as zero.
                            if (id_counter == 0)
                                id_counter = 1;
                        end
                        expect_outcome(make_outcome(RES_ADDED, id));
                    end
                end
            end
            OP_CANCEL:
            begin
                slot = lookup_ident(r.ident);
                if (slot < 0)
                    expect_outcome(make_outcome(RES_NOT_FOUND, r.ident));
                else
                begin
                    book_valid[slot] = 1'b0;
                    expect_outcome(make_outcome(RES_CANCELLED, r.ident));
                end
            end
            OP_CHECK:
            begin
                released = 0;
                // Buys first, then sells.
                for (int s = 1; s >= 0; s--)
                begin
                    forever
                    begin
                        slot = next_to_fire(s[0], r.trade);
                        if (slot < 0)
                            break;
                        o = make_outcome(RES_RELEASED, book_ident[slot]);
                        o.buy = book_buy[slot];
                        o.is_lim = (book_kind[slot] == KIND_LIMIT);
                        o.level = o.is_lim ? book_limit[slot] : '0;
                        o.qty = book_qty[slot];
                        o.last = 1'b0;
                        book_valid[slot] = 1'b0;
                        expect_outcome(o);
                        released++;
                    end
                end
                if (released == 0)
                    expect_outcome(make_outcome(RES_NONE, '0));
                else
                    expected_outcomes[$].last = 1'b1;
            end
            OP_TRAIL:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!book_valid[i] || book_kind[i] != KIND_TRAIL)
                        continue;
                    if (book_buy[i])
                    begin
                        if (r.trade < book_best[i])
                        begin
                            // A buy stop trails above the best price, capped at the top.
                            headroom = 32'hFFFF_FFFF - book_gap[i];
                            book_best[i] = r.trade;
                            book_stop[i] = (r.trade > headroom) ? 32'hFFFF_FFFF
                                                                : r.trade + book_gap[i];
                        end
                    end
                    else if (r.trade > book_best[i])
                    begin
                        // A sell stop trails below the best price, floored at zero.
                        book_best[i] = r.trade;
                        book_stop[i] = (r.trade >= book_gap[i]) ? r.trade - book_gap[i]
                                                                : '0;
                    end
                end
                expect_outcome(make_outcome(RES_UPDATED, '0));
            end
            default:
            begin
                // Spare operation codes leave the table alone and say nothing.
            end
        endcase
    endtask

    // Driver: issues queued requests in bursts with random gaps between them.
    int burst_left = 0;
    int gap_left = 0;
    bit taken = 0;
    always @(negedge clk)
    begin
        request_t r;
        if (rst_n && start && !taken)
        begin
            // The request on the ports has not been taken yet; keep it there.
        end
        else if (rst_n)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_requests.size() > 0)
            begin
                r = pending_requests.pop_front();
                op <= r.op;
                ident <= r.ident;
                buy_side <= r.buy;
                kind_code <= r.kind;
                stop_level <= r.stop;
                limit_level <= r.limit;
                trail_gap <= r.gap;
                qty <= r.qty;
                trade_level <= r.trade;
                replay_best <= r.rbest;
                start <= 1'b1;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 8);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                start <= 1'b0;
        end
    end

    // Acceptance: a request is taken at the rising edge where start is high and busy low.
    always @(posedge clk)
    begin
        request_t r;
        taken = rst_n && start && !busy;
        if (rst_n && start && !busy)
        begin
            r.op = op;
            r.ident = ident;
            r.buy = buy_side;
            r.kind = kind_code;
            r.stop = stop_level;
            r.limit = limit_level;
            r.gap = trail_gap;
            r.qty = qty;
            r.trade = trade_level;
            r.rbest = replay_best;
            predict_request(r);
        end
    end

    // Monitor: each strobed result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        outcome_t w;
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $error("unexpected result kind %0d ident %0d", result_kind, out_ident);
                failures++;
            end
            else
            begin
                w = expected_outcomes.pop_front();
                if (result_kind !== w.kind)
                begin
                    $error("result_kind expected %0d got %0d", w.kind, result_kind);
                    failures++;
                end
                if (out_ident !== w.ident)
                begin
                    $error("out_ident expected %0d got %0d", w.ident, out_ident);
                    failures++;
                end
                if (out_buy_side !== w.buy)
                begin
                    $error("out_buy_side expected %0d got %0d", w.buy, out_buy_side);
                    failures++;
                end
                if (is_limit !== w.is_lim)
                begin
                    $error("is_limit expected %0d got %0d", w.is_lim, is_limit);
                    failures++;
                end
                if (out_level !== w.level)
                begin
                    $error("out_level expected %0d got %0d", w.level, out_level);
                    failures++;
                end
                if (out_qty !== w.qty)
                begin
                    $error("out_qty expected %0d got %0d", w.qty, out_qty);
                    failures++;
                end
                if (last !== w.last)
                begin
                    $error("last expected %0d got %0d", w.last, last);
                    failures++;
                end
            end
        end
    end

    // Ids handed out so far, so that cancels and duplicates hit live orders.
    logic [31:0] known_ids[$];
    int          requests_queued = 0;

    function automatic request_t blank_request(logic [2:0] code);
        request_t r;
        r.op = code;
        r.ident = '0;
        r.buy = 1'b0;
        r.kind = KIND_MARKET;
        r.stop = '0;
        r.limit = '0;
        r.gap = '0;
        r.qty = '0;
        r.trade = '0;
        r.rbest = '0;
        return r;
    endfunction

    task automatic queue_request(request_t r);
        pending_requests.insert(pending_requests.size(), r);
        requests_queued++;
    endtask

    task automatic queue_order(logic [2:0] code, logic [31:0] id, logic side,
                               logic [1:0] k, logic [31:0] stop, logic [31:0] gap,
                               logic [31:0] best);
        request_t r;
        r = blank_request(code);
        r.ident = id;
        r.buy = side;
        r.kind = k;
        r.stop = stop;
        r.limit = $urandom;
        r.gap = gap;
        r.qty = $urandom;
        r.rbest = best;
        queue_request(r);
    endtask

    task automatic queue_market(logic [2:0] code, logic [31:0] trade);
        request_t r;
        r = blank_request(code);
        r.trade = trade;
        r.ident = $urandom;
        queue_request(r);
    endtask

    // Prices are drawn mostly near a moving center so that orders fire and tie.
    function automatic logic [31:0] near_price(logic [31:0] center);
        case ($urandom_range(0, 9))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: return $urandom_range(0, 3);
            2: return $urandom;
            default: return center + $urandom_range(0, 40) - 20;
        endcase
    endfunction

    task automatic random_request(logic [31:0] center);
        request_t r;
        int pick_op;
        r = blank_request(OP_ADD);
        pick_op = $urandom_range(0, 99);
        r.buy = 1'($urandom_range(0, 1));
        r.kind = 2'($urandom_range(0, 3));
        r.stop = near_price(center);
        r.limit = $urandom;
        r.gap = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 30);
        r.qty = $urandom;
        r.trade = near_price(center);
        r.rbest = near_price(center);
        if (pick_op < 35)
            r.ident = ($urandom_range(0, 4) == 0 && known_ids.size() > 0) ?
                      known_ids[$urandom_range(0, known_ids.size() - 1)] : '0;
        else if (pick_op < 45)
        begin
            r.op = OP_REPLAY;
            r.ident = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom;
            known_ids.insert(known_ids.size(), r.ident);
        end
        else if (pick_op < 60)
        begin
            r.op = OP_CANCEL;
            r.ident = (known_ids.size() > 0 && $urandom_range(0, 3) != 0) ?
                      known_ids[$urandom_range(0, known_ids.size() - 1)] : $urandom;
        end
        else if (pick_op < 80)
            r.op = OP_CHECK;
        else if (pick_op < 97)
            r.op = OP_TRAIL;
        else
        begin
            r.op = OP_SPARE + 3'($urandom_range(0, 2));
            r.ident = $urandom;
        end
        queue_request(r);
    endtask

    initial
    begin
        logic [31:0] center;
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_ADD;
        ident = '0;
        buy_side = 1'b0;
        kind_code = KIND_MARKET;
        stop_level = '0;
        limit_level = '0;
        trail_gap = '0;
        qty = '0;
        trade_level = '0;
        replay_best = '0;
        for (int i = 0; i < SLOTS; i++)
            book_valid[i] = 1'b0;
        id_counter = 1;
        insert_stamp = 0;

        // Directed part. An empty check and a trail on an empty table come first.
        queue_market(OP_CHECK, 32'd100);
        queue_market(OP_TRAIL, 32'd100);
        // Assigned ids 1 and 2, then an explicit id that collides with 2.
        queue_order(OP_ADD, '0, 1'b1, KIND_MARKET, 32'd50, '0, '0);
        queue_order(OP_ADD, '0, 1'b1, KIND_LIMIT, 32'd50, '0, '0);
        queue_order(OP_ADD, 32'd2, 1'b0, KIND_MARKET, 32'd10, '0, '0);
        // Replay with id zero, and the odd kind code that acts as stop market.
        queue_order(OP_REPLAY, '0, 1'b0, KIND_ODD, 32'hFFFF_FFFF, '0, 32'd7);
        queue_order(OP_ADD, 32'hFFFF_FFFF, 1'b0, KIND_LIMIT, '0, '0, '0);
        // Trailing stops that saturate at both ends of the price range.
        queue_order(OP_REPLAY, 32'd900, 1'b1, KIND_TRAIL, 32'hFFFF_FFF0,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_order(OP_REPLAY, 32'd901, 1'b0, KIND_TRAIL, '0, 32'hFFFF_FFFF, '0);
        queue_market(OP_TRAIL, 32'd5);
        queue_market(OP_SPARE, 32'd5);
        queue_market(OP_CANCEL, 32'd77);
        queue_order(OP_CANCEL, 32'd901, 1'b0, KIND_MARKET, '0, '0, '0);
        // Releases both sides with ties on level.
        queue_market(OP_CHECK, 32'd50);
        queue_market(OP_CHECK, 32'hFFFF_FFFF);
        queue_market(OP_CHECK, '0);
        // Fill the table to the brim, then one more add.
        for (int i = 0; i <= SLOTS; i++)
            queue_order(OP_ADD, '0, i[0], KIND_LIMIT, 32'd1000, '0, '0);
        queue_market(OP_CHECK, '0);
        queue_market(OP_CHECK, 32'hFFFF_FFFF);
        known_ids.insert(known_ids.size(), 32'd1);
        known_ids.insert(known_ids.size(), 32'd900);

        // Random part around a drifting price.
        center = 32'd5000;
        while (requests_queued < 430)
        begin
            if ($urandom_range(0, 40) == 0)
                center = $urandom;
            center = center + $urandom_range(0, 10) - 5;
            random_request(center);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_requests.size() == 0);
        @(posedge clk);
        while (start || busy || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && expected_outcomes.size() == 0)
            $display("stop_order_trigger_table_tb OK");
        else
            $display("stop_order_trigger_table_tb NOT OK");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/sott_pkg.sv
sv/sott_cand.sv
sv/stop_order_trigger_table.sv
tb/sv/stop_order_trigger_table_tb.sv
